// ----- rtl/core/alc_pkg.sv -----
package alc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 24;
  localparam int LIMB_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int TAG_W           = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_APERTURE_ENABLE = 3'd0,
    REG_SHAPE_CODE      = 3'd1,
    REG_X_HALF_SIZE     = 3'd2,
    REG_Y_HALF_SIZE     = 3'd3,
    REG_X_OFFSET        = 3'd4,
    REG_Y_OFFSET        = 3'd5,
    REG_MAX_RADIUS      = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE    = 3'd0,
    SHAPE_ELLIPSE   = 3'd1,
    SHAPE_RECTANGLE = 3'd2,
    SHAPE_DIAMOND   = 3'd3
  } shape_t;

endpackage

// ----- rtl/core/alc_in_if.sv -----
interface alc_in_if #(
  parameter int COORD_WIDTH = alc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_position;
  logic signed [COORD_WIDTH-1:0] y_position;
  logic                          already_lost;
  logic [alc_pkg::TAG_W-1:0]     particle_index;

  modport source (
    output valid, x_position, y_position, already_lost, particle_index,
    input  ready
  );
  modport sink (
    input  valid, x_position, y_position, already_lost, particle_index,
    output ready
  );
endinterface

// ----- rtl/core/alc_out_if.sv -----
interface alc_out_if;
  logic                      valid;
  logic                      ready;
  logic [alc_pkg::TAG_W-1:0] tag_out;
  logic                      lost;
  logic                      newly_lost;

  modport source (
    output valid, tag_out, lost, newly_lost,
    input  ready
  );
  modport sink (
    input  valid, tag_out, lost, newly_lost,
    output ready
  );
endinterface

// ----- rtl/core/alc_cfg_if.sv -----
interface alc_cfg_if #(
  parameter int COORD_WIDTH = alc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [alc_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_WIDTH-1:0]        data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/core/alc_mul.sv -----
module alc_mul #(
  parameter int WA = alc_pkg::COORD_WIDTH_DEF,
  parameter int WB = alc_pkg::COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  import alc_pkg::*;

  localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int PA = NA * LIMB_W;
  localparam int PB = NB * LIMB_W;
  localparam int RW = PB + LIMB_W;
  localparam int WP = WA + WB;

  logic [PA-1:0]         a_pad;
  logic [PB-1:0]         b_pad;
  logic [2*LIMB_W-1:0]   pp_r [NA][NB];
  logic [RW-1:0]         row_nxt [NA];
  logic [RW-1:0]         row_r [NA];
  logic [WP-1:0]         p_nxt;
  logic [WP-1:0]         p_r;

  assign a_pad = PA'(a);
  assign b_pad = PB'(b);

  // stage 1: limb by limb partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W]) *
                        (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
        end
      end
    end
  end

  // stage 2: one row per limb of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (j * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_nxt;
    end
  end

  // stage 3: fold the rows; bits above WP are known zero in the true product
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (WP'(row_r[i]) << (i * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/aperture_loss_check_unit.sv -----
// A word's result reaches the output through the input stage (loaded at the accepting edge),
// 3-stage products, 3-stage squares and the output register.
// Throughput: one word per cycle; the pipeline holds as a whole while the output word waits.
// Reset (rst_n low, synchronous): pipeline empty, registers to their defaults,
// max_radius to 1.0 in Q8.24.
module aperture_loss_check_unit #(
  parameter int COORD_WIDTH = alc_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  alc_in_if.sink    in_chan,
  alc_out_if.source out_chan,
  alc_cfg_if.sink   cfg_chan
);
  import alc_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int MW    = 2 * W;
  localparam int SW    = 4 * W;
  localparam int NSTG  = 7;

  typedef struct packed {
    logic             was_lost;
    logic [TAG_W-1:0] tag;
    logic             xy_zero;
    logic             rect_pass;
    logic             near_pass;
  } side_t;

  // configuration
  logic         ap_en_r;
  logic [2:0]   shape_r;
  logic [W-2:0] xh_r;
  logic [W-2:0] yh_r;
  logic [W-1:0] xoff_r;
  logic [W-1:0] yoff_r;
  logic [W-2:0] maxr_r;

  logic         cfg_wr;
  logic [W-2:0] half_a0;
  logic [W-2:0] half_b0;
  logic [W-2:0] half_a;
  logic [W-2:0] half_b;
  logic         degen;
  logic         circ;

  // pipeline
  logic          adv;
  logic [NSTG:1] vld_r;
  side_t         side_r [1:NSTG];

  logic [W:0]    dx;
  logic [W:0]    dy;
  logic [W:0]    dx_abs;
  logic [W:0]    dy_abs;
  logic [W-1:0]  x_abs_r;
  logic [W-1:0]  y_abs_r;

  logic [W-1:0]  op1b;
  logic [W-1:0]  op2b;
  logic [W-1:0]  op3a;
  logic [W-1:0]  op3b;
  logic [MW-1:0] m1;
  logic [MW-1:0] m2;
  logic [MW-1:0] m3;
  logic [MW:0]   near_sum;
  logic          near_ok;

  logic [SW-1:0] s1;
  logic [SW-1:0] s2;
  logic [SW-1:0] s3;
  logic [SW:0]   far_sum;
  logic          far_ok;
  logic          pass;

  logic             out_valid_r;
  logic [TAG_W-1:0] tag_r;
  logic             lost_r;
  logic             newly_r;

  // ---------------- configuration port ----------------
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_en_r <= 1'b0;
      shape_r <= '0;
      xh_r    <= '0;
      yh_r    <= '0;
      xoff_r  <= '0;
      yoff_r  <= '0;
      maxr_r  <= (W-1)'(64'd1 << FRAC_BITS);
    end else if (cfg_wr) begin
      unique case (cfg_chan.index)
        REG_APERTURE_ENABLE: ap_en_r <= cfg_chan.data[0];
        REG_SHAPE_CODE:      shape_r <= cfg_chan.data[2:0];
        REG_X_HALF_SIZE:     xh_r    <= cfg_chan.data[W-2:0];
        REG_Y_HALF_SIZE:     yh_r    <= cfg_chan.data[W-2:0];
        REG_X_OFFSET:        xoff_r  <= cfg_chan.data;
        REG_Y_OFFSET:        yoff_r  <= cfg_chan.data;
        REG_MAX_RADIUS:      maxr_r  <= cfg_chan.data[W-2:0];
        default: ;
      endcase
    end
  end

  // fill missing half sizes from each other, then from the default radius, which is also used when the aperture is off
  always_comb begin
    half_a0 = (xh_r == '0) ? yh_r : xh_r;
    half_b0 = (yh_r == '0) ? half_a0 : yh_r;
    if (!ap_en_r || half_b0 == '0) begin
      half_a = maxr_r;
      half_b = maxr_r;
    end else begin
      half_a = half_a0;
      half_b = half_b0;
    end
  end

  assign degen = (half_a == '0);
  assign circ  = !ap_en_r || (shape_r == SHAPE_CIRCLE);

  // ---------------- pipeline control ----------------
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:1], in_chan.valid};
    end
  end

  // ---------------- stage 1: offset and magnitude ----------------
  always_comb begin
    dx = {in_chan.x_position[W-1], in_chan.x_position};
    dy = {in_chan.y_position[W-1], in_chan.y_position};
    if (ap_en_r) begin
      dx = dx - {xoff_r[W-1], xoff_r};
      dy = dy - {yoff_r[W-1], yoff_r};
    end
    dx_abs = dx[W] ? (~dx + 1'b1) : dx;
    dy_abs = dy[W] ? (~dy + 1'b1) : dy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_abs_r <= dx_abs[W-1:0];
      y_abs_r <= dy_abs[W-1:0];
      side_r[1] <= '{was_lost: in_chan.already_lost, tag: in_chan.particle_index,
                     xy_zero: 1'b0, rect_pass: 1'b0, near_pass: 1'b0};
    end
  end

  // ---------------- stages 2..4: first products ----------------
  // circle: X*X, Y*Y, A*A; ellipse and diamond: X*B, Y*A, A*B
  assign op1b = circ ? x_abs_r : W'(half_b);
  assign op2b = circ ? y_abs_r : W'(half_a);
  assign op3a = W'(half_a);
  assign op3b = circ ? W'(half_a) : W'(half_b);

  alc_mul #(.WA(W), .WB(W)) u_mul1 (.clk(clk), .en(adv), .a(x_abs_r), .b(op1b), .p(m1));
  alc_mul #(.WA(W), .WB(W)) u_mul2 (.clk(clk), .en(adv), .a(y_abs_r), .b(op2b), .p(m2));
  alc_mul #(.WA(W), .WB(W)) u_mul3 (.clk(clk), .en(adv), .a(op3a),    .b(op3b), .p(m3));

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[2] <= '{was_lost: side_r[1].was_lost, tag: side_r[1].tag,
                     xy_zero: (x_abs_r == '0) && (y_abs_r == '0),
                     rect_pass: (x_abs_r <= W'(half_a)) && (y_abs_r <= W'(half_b)),
                     near_pass: 1'b0};
      side_r[3] <= side_r[2];
      side_r[4] <= side_r[3];
    end
  end

  // ---------------- stages 5..7: squares for the ellipse ----------------
  // ellipse test becomes (X*B)^2 + (Y*A)^2 <= (A*B)^2
  alc_mul #(.WA(MW), .WB(MW)) u_sq1 (.clk(clk), .en(adv), .a(m1), .b(m1), .p(s1));
  alc_mul #(.WA(MW), .WB(MW)) u_sq2 (.clk(clk), .en(adv), .a(m2), .b(m2), .p(s2));
  alc_mul #(.WA(MW), .WB(MW)) u_sq3 (.clk(clk), .en(adv), .a(m3), .b(m3), .p(s3));

  assign near_sum = {1'b0, m1} + {1'b0, m2};
  // default radius test is strict, aperture tests allow the boundary
  assign near_ok  = ap_en_r ? (near_sum <= {1'b0, m3}) : (near_sum < {1'b0, m3});

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[5] <= '{was_lost: side_r[4].was_lost, tag: side_r[4].tag,
                     xy_zero: side_r[4].xy_zero, rect_pass: side_r[4].rect_pass,
                     near_pass: near_ok};
      side_r[6] <= side_r[5];
      side_r[7] <= side_r[6];
    end
  end

  // ---------------- final decision and output register ----------------
  assign far_sum = {1'b0, s1} + {1'b0, s2};
  assign far_ok  = (far_sum <= {1'b0, s3});

  always_comb begin
    if (!ap_en_r) begin
      pass = side_r[NSTG].near_pass;
    end else begin
      unique case (shape_r)
        SHAPE_CIRCLE:    pass = side_r[NSTG].near_pass;
        SHAPE_ELLIPSE:   pass = degen ? side_r[NSTG].xy_zero : far_ok;
        SHAPE_RECTANGLE: pass = side_r[NSTG].rect_pass;
        SHAPE_DIAMOND:   pass = side_r[NSTG].near_pass;
        default:         pass = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r   <= side_r[NSTG].tag;
      lost_r  <= side_r[NSTG].was_lost || !pass;
      newly_r <= !side_r[NSTG].was_lost && !pass;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.tag_out    = tag_r;
  assign out_chan.lost       = lost_r;
  assign out_chan.newly_lost = newly_r;

endmodule

// ----- dv/aperture_loss_check_unit_tb.sv -----
`timescale 1ns / 1ps

module aperture_loss_check_unit_tb;
  import alc_pkg::*;

  localparam int COORD_WIDTH = COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 200;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 45;
  localparam int DIR_COUNT   = 22;

  // Register slot past the end of the list, and the shape codes with no test
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
  localparam logic [2:0]           SHAPE_NONE_LO = 3'd4;
  localparam logic [2:0]           SHAPE_NONE_HI = 3'd7;

  // Q8.24 values used by the directed table
  localparam logic [31:0] ONE  = 32'h0100_0000;
  localparam logic [31:0] TWO  = 32'h0200_0000;
  localparam logic [31:0] DXO  = 32'h0080_0000;  // +0.5
  localparam logic [31:0] DYO  = 32'hFFC0_0000;  // -0.25
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-2:0]        half_t;
  typedef logic [255:0]                  wide_t;

  typedef struct {
    logic [TAG_W-1:0] tag;
    logic             lost;
    logic             newly;
  } loss_verdict_t;

  typedef struct packed {
    logic             en;
    logic [2:0]       shape;
    logic [31:0]      xh;
    logic [31:0]      yh;
    logic [31:0]      rad;
    coord_t           xp;
    coord_t           yp;
    logic             gone;
    logic [TAG_W-1:0] tag;
    logic             typed;
    logic             t_lost;
    logic             t_newly;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_COUNT] = '{
    // default radius test
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0},
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, ONE, 32'd0, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1},
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, 32'h00FF_FFFF, 32'd0, 1'b0, 16'h0001,
      1'b1, 1'b0, 1'b0},
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, MAXP, MAXP, 1'b0, 16'h8000, 1'b1, 1'b1, 1'b1},
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, MINN, MINN, 1'b0, 16'h7FFF, 1'b1, 1'b1, 1'b1},
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 1'b1, 16'h1234, 1'b1, 1'b1, 1'b0},
    '{1'b0, SHAPE_CIRCLE, 32'd0, 32'd0, ONE, 32'hFF66_6666, 32'h00B3_3333, 1'b0, 16'h0007,
      1'b0, 1'b0, 1'b0},
    // each shape: a point on the x edge, then one that only some shapes keep
    '{1'b1, SHAPE_CIRCLE, TWO, ONE, ONE, 32'h0280_0000, DYO, 1'b0, 16'h0010, 1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_CIRCLE, TWO, ONE, ONE, 32'h0200_0000, 32'h00A6_6666, 1'b0, 16'h0011,
      1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_ELLIPSE, TWO, ONE, ONE, 32'h0280_0000, DYO, 1'b0, 16'h0012, 1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_ELLIPSE, TWO, ONE, ONE, 32'h0200_0000, 32'h00A6_6666, 1'b0, 16'h0013,
      1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_RECTANGLE, TWO, ONE, ONE, 32'h0280_0000, DYO, 1'b0, 16'h0014,
      1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_RECTANGLE, TWO, ONE, ONE, 32'h0200_0000, 32'h00A6_6666, 1'b0, 16'h0015,
      1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_DIAMOND, TWO, ONE, ONE, 32'h0280_0000, DYO, 1'b0, 16'h0016, 1'b0, 1'b0, 1'b0},
    '{1'b1, SHAPE_DIAMOND, TWO, ONE, ONE, 32'h0200_0000, 32'h00A6_6666, 1'b0, 16'h0017,
      1'b0, 1'b0, 1'b0},
    // codes without a test never lose a live particle
    '{1'b1, SHAPE_NONE_LO, TWO, ONE, ONE, MAXP, MINN, 1'b0, 16'h0020, 1'b1, 1'b0, 1'b0},
    '{1'b1, SHAPE_NONE_HI, TWO, ONE, ONE, MINN, MAXP, 1'b1, 16'h0021, 1'b1, 1'b1, 1'b0},
    // zero half sizes with a zero radius
    '{1'b1, SHAPE_ELLIPSE, 32'd0, 32'd0, 32'd0, DXO, DYO, 1'b0, 16'h0030, 1'b1, 1'b0, 1'b0},
    '{1'b1, SHAPE_ELLIPSE, 32'd0, 32'd0, 32'd0, 32'h0180_0000, DYO, 1'b0, 16'h0031,
      1'b1, 1'b1, 1'b1},
    '{1'b1, SHAPE_DIAMOND, 32'd0, 32'd0, 32'd0, MAXP, MINN, 1'b0, 16'h0032, 1'b1, 1'b0, 1'b0},
    '{1'b1, SHAPE_RECTANGLE, 32'd0, 32'd0, 32'd0, DXO, 32'h00C0_0000, 1'b0, 16'h0033,
      1'b1, 1'b1, 1'b1},
    // x half size missing, taken from y
    '{1'b1, SHAPE_CIRCLE, 32'd0, ONE, ONE, 32'h0180_0000, DYO, 1'b0, 16'h0034, 1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst_n;

  alc_in_if  #(.COORD_WIDTH(COORD_WIDTH)) in_chan ();
  alc_out_if                              out_chan ();
  alc_cfg_if #(.COORD_WIDTH(COORD_WIDTH)) cfg_chan ();

  aperture_loss_check_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Local copy of the aperture registers, reset values
  logic       ap_enable = 1'b0;
  logic [2:0] ap_shape  = SHAPE_CIRCLE;
  half_t      ap_x_half = '0;
  half_t      ap_y_half = '0;
  coord_t     ap_x_off  = '0;
  coord_t     ap_y_off  = '0;
  half_t      ap_radius = half_t'(32'h0100_0000);

  loss_verdict_t pending_verdicts[$];
  int  mismatch_count = 0;
  int  words_checked  = 0;
  int  lost_seen      = 0;
  int  settings_used  = 0;
  int  cycle_count    = 0;
  bit  idle_on        = 1'b1;
  bit  hold_request   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Zero half size takes the other one; both zero falls back to the radius
  function automatic void fill_halves(output half_t a, output half_t b);
    a = ap_x_half;
    b = ap_y_half;
    if (a == 0) a = b;
    if (b == 0) b = a;
    if (b == 0) begin
      a = ap_radius;
      b = ap_radius;
    end
  endfunction

  function automatic bit particle_survives(coord_t xp, coord_t yp);
    logic signed [COORD_WIDTH+1:0] dx, dy;
    wide_t dev_x, dev_y, ha, hb, r;
    half_t a, b;
    if (!ap_enable) begin
      dx = (COORD_WIDTH+2)'(xp);
      dy = (COORD_WIDTH+2)'(yp);
    end else begin
      dx = (COORD_WIDTH+2)'(xp) - (COORD_WIDTH+2)'(ap_x_off);
      dy = (COORD_WIDTH+2)'(yp) - (COORD_WIDTH+2)'(ap_y_off);
    end
    dev_x = wide_t'(dx < 0 ? -dx : dx);
    dev_y = wide_t'(dy < 0 ? -dy : dy);
    if (!ap_enable) begin
      r = wide_t'(ap_radius);
      return dev_x * dev_x + dev_y * dev_y < r * r;
    end
    fill_halves(a, b);
    ha = wide_t'(a);
    hb = wide_t'(b);
    case (ap_shape)
      SHAPE_CIRCLE: return dev_x * dev_x + dev_y * dev_y <= ha * ha;
      SHAPE_ELLIPSE: begin
        if (ha == 0 || hb == 0) return dev_x == 0 && dev_y == 0;
        return dev_x * dev_x * hb * hb + dev_y * dev_y * ha * ha <= ha * ha * hb * hb;
      end
      SHAPE_RECTANGLE: return dev_x <= ha && dev_y <= hb;
      SHAPE_DIAMOND: return ha * dev_y + hb * dev_x <= ha * hb;
      default: return 1'b1;
    endcase
  endfunction

  function automatic loss_verdict_t predict_verdict(coord_t xp, coord_t yp, logic gone,
                                                    logic [TAG_W-1:0] tag);
    loss_verdict_t v;
    v.tag   = tag;
    v.lost  = gone ? 1'b1 : !particle_survives(xp, yp);
    v.newly = gone ? 1'b0 : v.lost;
    return v;
  endfunction

  // Coordinate around a center: anywhere, on an edge (+/-1 lsb), at the center,
  // or spread over twice the span
  function automatic coord_t pick_coord(coord_t center, longint span);
    longint d;
    case ($urandom_range(0, 6))
      0: return coord_t'($urandom);
      1: d = span + longint'($urandom_range(0, 2)) - 1;
      2: d = -span - longint'($urandom_range(0, 2)) + 1;
      3: d = 0;
      default: d = (longint'($signed($urandom)) * span) >>> 30;
    endcase
    return coord_t'(longint'(center) + d);
  endfunction

  // write_reg and send_particle start after a rising edge and leave their valid high
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_WIDTH-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_APERTURE_ENABLE: ap_enable = data[0];
      REG_SHAPE_CODE:      ap_shape  = data[2:0];
      REG_X_HALF_SIZE:     ap_x_half = data[COORD_WIDTH-2:0];
      REG_Y_HALF_SIZE:     ap_y_half = data[COORD_WIDTH-2:0];
      REG_X_OFFSET:        ap_x_off  = data;
      REG_Y_OFFSET:        ap_y_off  = data;
      REG_MAX_RADIUS:      ap_radius = data[COORD_WIDTH-2:0];
      default: ;
    endcase
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    repeat (n - 1) @(posedge clk);
  endtask

  task automatic set_config(logic en, logic [2:0] shape, logic [31:0] xh, logic [31:0] yh,
                            logic [31:0] xo, logic [31:0] yo, logic [31:0] rad);
    pause_sender(1);
    while (pending_verdicts.size() != 0) @(posedge clk);
    write_reg(REG_APERTURE_ENABLE, {31'd0, en});
    write_reg(REG_SHAPE_CODE, {29'd0, shape});
    write_reg(REG_X_HALF_SIZE, xh);
    write_reg(REG_Y_HALF_SIZE, yh);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_OFFSET, yo);
    write_reg(REG_MAX_RADIUS, rad);
    write_reg(REG_UNUSED, $urandom);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_particle(coord_t xp, coord_t yp, logic gone, logic [TAG_W-1:0] tag,
                               logic typed, logic t_lost, logic t_newly);
    loss_verdict_t v;
    @(negedge clk);
    in_chan.valid          <= 1'b1;
    in_chan.x_position     <= xp;
    in_chan.y_position     <= yp;
    in_chan.already_lost   <= gone;
    in_chan.particle_index <= tag;
    do @(posedge clk); while (!in_chan.ready);
    if (typed) begin
      v.tag   = tag;
      v.lost  = t_lost;
      v.newly = t_newly;
    end else begin
      v = predict_verdict(xp, yp, gone, tag);
    end
    pending_verdicts.push_back(v);
  endtask

  // Output ready: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    loss_verdict_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("unexpected word, tag %h", out_chan.tag_out));
      end else begin
        want = pending_verdicts.pop_front();
        words_checked++;
        if (out_chan.lost === 1'b1) lost_seen++;
        if (out_chan.tag_out !== want.tag)
          flag_error($sformatf("tag_out %h, expected %h", out_chan.tag_out, want.tag));
        if (out_chan.lost !== want.lost)
          flag_error($sformatf("tag %h: lost %b, expected %b", want.tag, out_chan.lost,
                               want.lost));
        if (out_chan.newly_lost !== want.newly)
          flag_error($sformatf("tag %h: newly_lost %b, expected %b", want.tag,
                               out_chan.newly_lost, want.newly));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d words outstanding",
             pending_verdicts.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [99:0] last_key;
    logic [99:0] key;
    dir_row_t    row;
    logic        r_en;
    logic [2:0]  r_shape;
    logic [31:0] r_xh, r_yh, r_xo, r_yo, r_rad;
    half_t       span_a, span_b;
    coord_t      cx, cy;
    bit          sender_gaps;

    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.x_position     = '0;
    in_chan.y_position     = '0;
    in_chan.already_lost   = 1'b0;
    in_chan.particle_index = '0;
    cfg_chan.valid         = 1'b0;
    cfg_chan.index         = REG_APERTURE_ENABLE;
    cfg_chan.data          = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    last_key = '1;
    for (int i = 0; i < DIR_COUNT; i++) begin
      row = DIRECTED[i];
      key = {row.en, row.shape, row.xh, row.yh, row.rad};
      if (key != last_key) begin
        set_config(row.en, row.shape, row.xh, row.yh, DXO, DYO, row.rad);
        last_key = key;
      end
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
      send_particle(row.xp, row.yp, row.gone, row.tag, row.typed, row.t_lost, row.t_newly);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r_en    = 1'b1;
      r_shape = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                            : 3'($urandom_range(0, 3));
      r_xh    = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
      r_yh    = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
      if ($urandom_range(0, 2) != 0) r_xh[30:27] = 4'd0;
      if ($urandom_range(0, 2) != 0) r_yh[30:27] = 4'd0;
      r_xo    = $signed($urandom) >>> $urandom_range(0, 6);
      r_yo    = $signed($urandom) >>> $urandom_range(0, 6);
      r_rad   = $urandom;
      if ($urandom_range(0, 2) != 0) r_rad[30:26] = 5'd0;
      if (r_rad[30:0] == 0) r_rad = 32'd1;
      case (ph)
        0: begin
          r_en  = 1'b0;
          r_rad = ONE;
        end
        1: begin
          r_en  = 1'b0;
          r_rad = MAXP;
        end
        2: begin
          r_shape = SHAPE_CIRCLE;
          r_xh    = 32'd0;
          r_yh    = 32'd0;
          r_rad   = 32'd1;
        end
        3: begin
          r_shape = SHAPE_ELLIPSE;
          r_xh    = MAXP;
          r_yh    = MAXP;
          r_xo    = MAXP;
          r_yo    = MINN;
        end
        4: begin
          r_shape = SHAPE_RECTANGLE;
          r_yh    = 32'd0;
        end
        5: begin
          r_shape = SHAPE_DIAMOND;
          r_xh    = 32'd0;
          r_xo    = MINN;
        end
        default: ;
      endcase
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      set_config(r_en, r_shape, r_xh, r_yh, r_xo, r_yo, r_rad);

      if (ap_enable) begin
        fill_halves(span_a, span_b);
        cx = ap_x_off;
        cy = ap_y_off;
      end else begin
        span_a = ap_radius;
        span_b = ap_radius;
        cx     = '0;
        cy     = '0;
      end

      // Hold the output long enough that the pipeline backs up into the input
      if (ph == 3) hold_request = 1'b1;
      sender_gaps = idle_on && ph != 3;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 6 && n == PHASE_WORDS / 2) begin
          pause_sender(1);
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
        if (sender_gaps && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 17));
        send_particle(pick_coord(cx, longint'(span_a)), pick_coord(cy, longint'(span_b)),
                      $urandom_range(0, 7) == 0, TAG_W'($urandom), 1'b0, 1'b0, 1'b0);
      end
    end

    pause_sender(1);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d particle words (%0d lost) over %0d aperture settings.",
             words_checked, lost_seen, settings_used);
    $display("Covered default radius, all shapes, open codes, zero half sizes, %0d-cycle hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/alc_pkg.sv
rtl/core/alc_in_if.sv
rtl/core/alc_out_if.sv
rtl/core/alc_cfg_if.sv
rtl/core/alc_mul.sv
rtl/core/aperture_loss_check_unit.sv
dv/aperture_loss_check_unit_tb.sv
